// File: rtl/twsw_pkg.sv
package twsw_pkg;

  localparam int XW = 33;
  localparam int ZW = 35;
  localparam int MAX_STAGES = 24;

  localparam logic signed [ZW-1:0] PI_Q30         = 35'sd3373259426;
  localparam logic signed [ZW-1:0] QUARTER_PI_Q30 = 35'sd843314856;
  localparam logic signed [30:0]   INV_GAIN_Q30   = 31'sd652032874;
  localparam logic signed [23:0]   SPEED_MAX      = 24'sh7FFFFF;
  localparam logic signed [23:0]   SPEED_MIN      = -24'sh800000;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic                 spin;
    logic signed [23:0]   spin_speed;
  } cordic_word_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/twsw_front.sv
module twsw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [15:0]      linear_x,
  input  logic signed [15:0]      linear_y,
  input  logic signed [15:0]      angular_z,
  input  logic [15:0]             inv_radius,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output twsw_pkg::cordic_word_t  dn_data
);

  logic                   v_r;
  twsw_pkg::cordic_word_t d_r;
  twsw_pkg::cordic_word_t d_nxt;

  logic signed [32:0] x0;
  logic signed [32:0] y0;
  logic signed [32:0] wp;
  logic signed [32:0] wr;

  always_comb begin
    x0 = {{3{linear_x[15]}}, linear_x, 14'b0};
    y0 = {{3{linear_y[15]}}, linear_y, 14'b0};
    wp = 33'(angular_z) * $signed({17'b0, inv_radius});
    wr = (wp + 33'sd128) >>> 8;
    d_nxt.zero = (linear_x == 16'sd0) && (linear_y == 16'sd0);
    d_nxt.spin = (angular_z != 16'sd0);
    if (x0[32]) begin
      d_nxt.x = -x0;
      d_nxt.y = -y0;
      d_nxt.z = y0[32] ? -twsw_pkg::PI_Q30 : twsw_pkg::PI_Q30;
    end else begin
      d_nxt.x = x0;
      d_nxt.y = y0;
      d_nxt.z = '0;
    end
    if (wr > 33'(twsw_pkg::SPEED_MAX)) d_nxt.spin_speed = twsw_pkg::SPEED_MAX;
    else if (wr < 33'(twsw_pkg::SPEED_MIN)) d_nxt.spin_speed = twsw_pkg::SPEED_MIN;
    else d_nxt.spin_speed = wr[23:0];
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

// File: rtl/twsw_cordic_cell.sv
module twsw_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  twsw_pkg::cordic_word_t  up_data,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output twsw_pkg::cordic_word_t  dn_data
);

  logic                   v_r;
  twsw_pkg::cordic_word_t d_r;
  twsw_pkg::cordic_word_t d_nxt;

  logic signed [twsw_pkg::XW-1:0] dx;
  logic signed [twsw_pkg::XW-1:0] dy;
  logic signed [twsw_pkg::ZW-1:0] da;

  always_comb begin
    dx = up_data.y >>> STAGE;
    dy = up_data.x >>> STAGE;
    da = $signed({{(twsw_pkg::ZW-30){1'b0}}, twsw_pkg::atan_q30(5'(STAGE))});
    d_nxt = up_data;
    if (!up_data.y[twsw_pkg::XW-1]) begin
      d_nxt.x = up_data.x + dx;
      d_nxt.y = up_data.y - dy;
      d_nxt.z = up_data.z + da;
    end else begin
      d_nxt.x = up_data.x - dx;
      d_nxt.y = up_data.y + dy;
      d_nxt.z = up_data.z - da;
    end
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

// File: rtl/twsw_post.sv
module twsw_post (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  twsw_pkg::cordic_word_t  up_data,
  input  logic [15:0]             inv_radius,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [15:0]      steer_plus,
  output logic signed [15:0]      steer_minus,
  output logic signed [23:0]      speed_left,
  output logic signed [23:0]      speed_right,
  output logic                    spin_mode
);

  // stage a: gain product, steering
  logic               va_r;
  logic signed [63:0] prod_g_r;
  logic signed [15:0] sp_a_r, sm_a_r;
  logic               zero_a_r, spin_a_r;
  logic signed [23:0] ss_a_r;
  // stage b: speed product
  logic               vb_r;
  logic signed [49:0] prod_s_r;
  logic signed [15:0] sp_b_r, sm_b_r;
  logic               spin_b_r;
  logic signed [23:0] ss_b_r;
  // stage c: output register
  logic               vc_r;
  logic signed [15:0] sp_c_r, sm_c_r;
  logic signed [23:0] sl_c_r, sr_c_r;
  logic               spin_c_r;

  logic rdy_a, rdy_b, rdy_c;

  logic signed [35:0] zp, zm;
  logic signed [18:0] zpr, zmr;
  logic signed [15:0] sp_nxt, sm_nxt;
  logic signed [63:0] prod_g_nxt;
  logic signed [33:0] mag_full;
  logic signed [32:0] mag;
  logic signed [49:0] prod_s_nxt;
  logic signed [27:0] raw;
  logic signed [27:0] nraw;
  logic signed [23:0] sl_nxt, sr_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] o;
    if (v > 19'sd32767) o = 16'sh7FFF;
    else if (v < -19'sd32768) o = -16'sh8000;
    else o = v[15:0];
    return o;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] o;
    if (v > 28'(twsw_pkg::SPEED_MAX)) o = twsw_pkg::SPEED_MAX;
    else if (v < 28'(twsw_pkg::SPEED_MIN)) o = twsw_pkg::SPEED_MIN;
    else o = v[23:0];
    return o;
  endfunction

  always_comb begin
    zp = (up_data.zero ? 36'sd0 : 36'(up_data.z)) + 36'(twsw_pkg::QUARTER_PI_Q30);
    zm = (up_data.zero ? 36'sd0 : 36'(up_data.z)) - 36'(twsw_pkg::QUARTER_PI_Q30);
    zpr = 19'((zp + 36'sd65536) >>> 17);
    zmr = 19'((zm + 36'sd65536) >>> 17);
    sp_nxt = sat16(zpr);
    sm_nxt = sat16(zmr);
    prod_g_nxt = 64'(up_data.x) * 64'(twsw_pkg::INV_GAIN_Q30);
  end

  always_comb begin
    mag_full = 34'((prod_g_r + 64'sd536870912) >>> 30);
    mag = zero_a_r ? '0 : mag_full[32:0];
    prod_s_nxt = 50'(mag) * $signed({34'b0, inv_radius});
  end

  always_comb begin
    raw  = 28'((prod_s_r + 50'sd2097152) >>> 22);
    nraw = -raw;
    sr_nxt = sat24(raw);
    sl_nxt = sat24(nraw);
  end

  assign rdy_c    = !vc_r || dn_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      prod_g_r <= prod_g_nxt;
      sp_a_r   <= sp_nxt;
      sm_a_r   <= sm_nxt;
      zero_a_r <= up_data.zero;
      spin_a_r <= up_data.spin;
      ss_a_r   <= up_data.spin_speed;
    end
    if (rdy_b && va_r) begin
      prod_s_r <= prod_s_nxt;
      sp_b_r   <= sp_a_r;
      sm_b_r   <= sm_a_r;
      spin_b_r <= spin_a_r;
      ss_b_r   <= ss_a_r;
    end
    if (rdy_c && vb_r) begin
      spin_c_r <= spin_b_r;
      if (spin_b_r) begin
        sp_c_r <= '0;
        sm_c_r <= '0;
        sl_c_r <= ss_b_r;
        sr_c_r <= ss_b_r;
      end else begin
        sp_c_r <= sp_b_r;
        sm_c_r <= sm_b_r;
        sl_c_r <= sl_nxt;
        sr_c_r <= sr_nxt;
      end
    end
  end

  assign dn_valid    = vc_r;
  assign steer_plus  = sp_c_r;
  assign steer_minus = sm_c_r;
  assign speed_left  = sl_c_r;
  assign speed_right = sr_c_r;
  assign spin_mode   = spin_c_r;

endmodule

// File: rtl/twist_to_swerve_wheel_commands_unit.sv
// Swerve drive inverse kinematics: one velocity command in, one set of four
// steering angles and four wheel speeds out per transaction.
// in_*: stream slave; one transaction carries linear x, linear y and angular z.
// out_*: stream master; one transaction carries the wheel commands, with
//   tuser set when the command was a spin (angular z nonzero).
// cfg_*: write channel for the inverse wheel radius (Q8.8); always ready.
//   Write only while no transaction is in flight.
// Pipeline: one entry cell, one cell per CORDIC vectoring stage (clamped to
//   24 stages), then gain multiply, speed multiply and the output register.
// Throughput: one transaction per cycle while out_tready stays high. Every
//   cell registers its data and has its own valid, so the chain keeps
//   filling while a result waits.
// Receiver stall: out_tready low holds the output register; cells behind it
//   keep taking data until full, then in_tready drops.
// Reset (synchronous, rst_n low): all cells empty, radius back to 20.0.
module twist_to_swerve_wheel_commands_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // linear_x, linear_y, angular_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // steer_left_front, steer_left_rear,
                                   // steer_right_front, steer_right_rear,
                                   // speed_left_front, speed_left_rear,
                                   // speed_right_front, speed_right_rear
  output logic         out_tuser,  // spin_mode
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // inverse_wheel_radius
);

  localparam int NSTG = (CORDIC_STAGES > twsw_pkg::MAX_STAGES) ?
                        twsw_pkg::MAX_STAGES : CORDIC_STAGES;

  logic [15:0] inv_radius_r;

  twsw_pkg::cordic_word_t stg_data [0:NSTG];
  logic                   stg_valid [0:NSTG];
  logic                   stg_ready [0:NSTG];

  logic signed [15:0] steer_plus, steer_minus;
  logic signed [23:0] speed_left, speed_right;
  logic               spin_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_radius_r <= 16'd5120;
    end else if (cfg_valid && cfg_ready) begin
      inv_radius_r <= cfg_data;
    end
  end

  twsw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .linear_x   (in_tdata[15:0]),
    .linear_y   (in_tdata[31:16]),
    .angular_z  (in_tdata[47:32]),
    .inv_radius (inv_radius_r),
    .dn_valid   (stg_valid[0]),
    .dn_ready   (stg_ready[0]),
    .dn_data    (stg_data[0])
  );

  for (genvar k = 0; k < NSTG; k++) begin : g_cell
    twsw_cordic_cell #(.STAGE(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_data  (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_data  (stg_data[k+1])
    );
  end

  twsw_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (stg_valid[NSTG]),
    .up_ready    (stg_ready[NSTG]),
    .up_data     (stg_data[NSTG]),
    .inv_radius  (inv_radius_r),
    .dn_valid    (out_tvalid),
    .dn_ready    (out_tready),
    .steer_plus  (steer_plus),
    .steer_minus (steer_minus),
    .speed_left  (speed_left),
    .speed_right (speed_right),
    .spin_mode   (spin_mode)
  );

  assign out_tdata = {speed_right, speed_right, speed_left, speed_left,
                      steer_plus, steer_minus, steer_minus, steer_plus};
  assign out_tuser = spin_mode;

  a_spin_no_steer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:0] == 64'd0)
    else $error("spin result with nonzero steering");

  a_spin_equal_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[159:136] == out_tdata[87:64])
    else $error("spin result with unequal wheel speeds");

  a_trans_right_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (!out_tdata[159] && out_tdata[87])
      || (out_tdata[159:64] == 96'd0))
    else $error("translation speeds with wrong signs");

  a_trans_steer_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:0] != out_tdata[31:16])
    else $error("translation steering pair not split");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CORDIC_STAGES = 16;
  localparam int RUN_STAGES    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int PIPE_LATENCY  = RUN_STAGES + 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RAND_PER_PHASE = 190;

  localparam longint ANG_PI      = 64'sd3373259426;
  localparam longint ANG_QTR_PI  = 64'sd843314856;
  localparam longint CORDIC_KINV = 64'sd652032874;
  localparam longint SPD_HI      = 64'sd8388607;
  localparam longint SPD_LO      = -64'sd8388608;
  localparam longint STEER_HI    = 64'sd32767;
  localparam longint STEER_LO    = -64'sd32768;

  // packed so that {out_tuser, out_tdata} maps straight onto it
  typedef struct packed {
    logic               spin;
    logic signed [23:0] speed_rr;
    logic signed [23:0] speed_rf;
    logic signed [23:0] speed_lr;
    logic signed [23:0] speed_lf;
    logic signed [15:0] steer_rr;
    logic signed [15:0] steer_rf;
    logic signed [15:0] steer_lr;
    logic signed [15:0] steer_lf;
  } wheel_cmd_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;     // linear_x, linear_y, angular_z
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;         // steer lf, lr, rf, rr, speed lf, lr, rf, rr
  logic         out_tuser;         // spin_mode
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;     // inverse_wheel_radius

  longint steer_atan_lut [24] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
  };

  logic [47:0] cmd_pending [$];
  wheel_cmd_t  wheel_expect [$];
  logic [15:0] inv_rad_model = 16'd5120;

  int  mismatches = 0;
  int  cmds_sent = 0;
  int  results_seen = 0;
  int  spins_seen = 0;
  int  radius_writes = 0;
  int  quiet_cycles = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  in_taken = 1'b0;

  twist_to_swerve_wheel_commands_unit #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic wheel_cmd_t swerve_ik(input logic signed [15:0] vx,
                                           input logic signed [15:0] vy,
                                           input logic signed [15:0] wz,
                                           input logic [15:0] r);
    wheel_cmd_t c;
    longint rr, cx, cy, dx, dy, ang, mag, raw, spd_l, spd_r, st_p, st_m;
    rr = longint'(r);
    if (wz != 0) begin
      spd_r = clip(round_shr(longint'(wz) * rr, 8), SPD_LO, SPD_HI);
      spd_l = spd_r;
      st_p = 0;
      st_m = 0;
      c.spin = 1'b1;
    end else begin
      cx = longint'(vx) * 16384;
      cy = longint'(vy) * 16384;
      ang = 0;
      mag = 0;
      if (vx != 0 || vy != 0) begin
        // fold the left half plane over, carrying +/-pi
        if (cx < 0) begin
          ang = (cy >= 0) ? ANG_PI : -ANG_PI;
          cx = -cx;
          cy = -cy;
        end
        for (int i = 0; i < RUN_STAGES; i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            ang += steer_atan_lut[i];
          end else begin
            cx -= dx;
            cy += dy;
            ang -= steer_atan_lut[i];
          end
        end
        mag = round_shr(cx * CORDIC_KINV, 30);
      end
      st_p = clip(round_shr(ang + ANG_QTR_PI, 17), STEER_LO, STEER_HI);
      st_m = clip(round_shr(ang - ANG_QTR_PI, 17), STEER_LO, STEER_HI);
      raw = round_shr(mag * rr, 22);
      spd_r = clip(raw, SPD_LO, SPD_HI);
      spd_l = clip(-raw, SPD_LO, SPD_HI);
      c.spin = 1'b0;
    end
    c.steer_lf = st_p[15:0];
    c.steer_rr = st_p[15:0];
    c.steer_lr = st_m[15:0];
    c.steer_rf = st_m[15:0];
    c.speed_lf = spd_l[23:0];
    c.speed_lr = spd_l[23:0];
    c.speed_rf = spd_r[23:0];
    c.speed_rr = spd_r[23:0];
    return c;
  endfunction

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 65535));
      3: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 50)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_wheels(input wheel_cmd_t got, input wheel_cmd_t want);
    if (got.steer_lf !== want.steer_lf)
      report_mismatch("steer_left_front", got.steer_lf, want.steer_lf);
    if (got.steer_lr !== want.steer_lr)
      report_mismatch("steer_left_rear", got.steer_lr, want.steer_lr);
    if (got.steer_rf !== want.steer_rf)
      report_mismatch("steer_right_front", got.steer_rf, want.steer_rf);
    if (got.steer_rr !== want.steer_rr)
      report_mismatch("steer_right_rear", got.steer_rr, want.steer_rr);
    if (got.speed_lf !== want.speed_lf)
      report_mismatch("speed_left_front", got.speed_lf, want.speed_lf);
    if (got.speed_lr !== want.speed_lr)
      report_mismatch("speed_left_rear", got.speed_lr, want.speed_lr);
    if (got.speed_rf !== want.speed_rf)
      report_mismatch("speed_right_front", got.speed_rf, want.speed_rf);
    if (got.speed_rr !== want.speed_rr)
      report_mismatch("speed_right_rear", got.speed_rr, want.speed_rr);
    if (got.spin !== want.spin)
      report_mismatch("spin_mode", got.spin, want.spin);
  endtask

  task automatic queue_cmd(input logic [15:0] vx, input logic [15:0] vy,
                           input logic [15:0] wz);
    cmd_pending.push_back({wz, vy, vx});
  endtask

  task automatic load_directed();
    queue_cmd(16'h0000, 16'h0000, 16'h0000);   // zero vector
    queue_cmd(16'h7FFF, 16'h0000, 16'h0000);
    queue_cmd(16'h8000, 16'h0000, 16'h0000);
    queue_cmd(16'h0000, 16'h7FFF, 16'h0000);
    queue_cmd(16'h0000, 16'h8000, 16'h0000);
    queue_cmd(16'h7FFF, 16'h7FFF, 16'h0000);
    queue_cmd(16'h8000, 16'h8000, 16'h0000);
    queue_cmd(16'h7FFF, 16'h8000, 16'h0000);
    queue_cmd(16'h8000, 16'h7FFF, 16'h0000);
    queue_cmd(16'hFFFF, 16'h0000, 16'h0000);   // negative x, y zero: +pi side
    queue_cmd(16'hFFFF, 16'hFFFF, 16'h0000);   // negative x, y negative: -pi side
    queue_cmd(16'hFFFF, 16'h0001, 16'h0000);
    queue_cmd(16'h0001, 16'h0000, 16'h0000);
    queue_cmd(16'h0000, 16'h0001, 16'h0000);
    queue_cmd(16'h0000, 16'hFFFF, 16'h0000);
    queue_cmd(16'h1000, 16'h1000, 16'h0000);
    queue_cmd(16'h0000, 16'h0000, 16'h0001);
    queue_cmd(16'h0000, 16'h0000, 16'hFFFF);
    queue_cmd(16'h0000, 16'h0000, 16'h7FFF);
    queue_cmd(16'h0000, 16'h0000, 16'h8000);
    queue_cmd(16'h8000, 16'h7FFF, 16'h8000);   // spin wins over linear
    queue_cmd(16'h0064, 16'hFF38, 16'h1000);
  endtask

  task automatic load_random(input int n);
    for (int k = 0; k < n; k++)
      queue_cmd(rand_field(), rand_field(),
                ($urandom_range(0, 2) == 0) ? rand_field() : 16'h0000);
  endtask

  task automatic settle();
    while (cmd_pending.size() != 0 || in_tvalid || wheel_expect.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_radius(input logic [15:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    inv_rad_model = v;
    radius_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (in_taken) begin
      nxt_valid = 1'b0;
      in_taken = 1'b0;
    end
    if (rst_n && !nxt_valid) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (cmd_pending.size() > 0) begin
        in_tdata <= cmd_pending.pop_front();
        nxt_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = draw_gap(tx_calm);
      end
    end
    in_tvalid <= nxt_valid;
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n && rx_stall == 0) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_stall > 0) rx_stall--;
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    wheel_cmd_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        wheel_expect.push_back(swerve_ik(in_tdata[15:0], in_tdata[31:16],
                                         in_tdata[47:32], inv_rad_model));
        in_taken = 1'b1;
        cmds_sent++;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (wheel_expect.size() == 0)
          report_mismatch("result with nothing pending", 0, 0);
        else
          check_wheels(got, wheel_expect.pop_front());
        results_seen++;
        if (got.spin === 1'b1) spins_seen++;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_stall = draw_gap(rx_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] radius_plan [5];
    radius_plan[0] = 16'd0;
    radius_plan[1] = 16'hFFFF;
    radius_plan[2] = 16'd1;
    radius_plan[3] = 16'($urandom_range(0, 65535));
    radius_plan[4] = 16'd5120;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_directed();
    load_random(RAND_PER_PHASE);
    settle();

    for (int p = 0; p < 5; p++) begin
      write_radius(radius_plan[p]);
      if (radius_plan[p] == 16'hFFFF) load_directed();
      load_random(RAND_PER_PHASE / 2);
      settle();
      load_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
      settle();
    end

    $display("%0d commands over %0d radius writes, %0d results checked (%0d spin)",
             cmds_sent, radius_writes, results_seen, spins_seen);
    $display("radius covered 0, 1, 20.0, max and one random value; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
